// ===== src/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the root counter timer: request kinds,
// register offsets, mode bit positions and divider settings.
// ----------------------------------------------------------------------------
package rct_pkg;

  // timer identity and prescaler dividers
  localparam int unsigned TIMER_INDEX = 0;
  localparam int unsigned LINE_DIVIDE = 2100;
  localparam int unsigned SYS_DIVIDE  = 8;

  // field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned OFF_W   = 4;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned PRESC_W = 12;
  localparam int unsigned MODE_W  = 13;

  // packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = ((OFF_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;

  // line-clock source path only exists on timer 1
  localparam bit LINE_PATH = (TIMER_INDEX == 1);
  localparam logic [PRESC_W-1:0] PRESC_DIVIDE =
    LINE_PATH ? PRESC_W'(LINE_DIVIDE) : PRESC_W'(SYS_DIVIDE);

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  // register offsets
  localparam logic [OFF_W-1:0] OFF_COUNT  = 4'h0;
  localparam logic [OFF_W-1:0] OFF_MODE   = 4'h4;
  localparam logic [OFF_W-1:0] OFF_TARGET = 4'h8;

  // mode bit positions
  localparam int unsigned MODE_TGT_RESET = 3;
  localparam int unsigned MODE_TGT_IRQ   = 4;
  localparam int unsigned MODE_OVF_IRQ   = 5;
  localparam int unsigned MODE_TOGGLE    = 7;
  localparam int unsigned MODE_SRC_ODD   = 8;
  localparam int unsigned MODE_NIRQ      = 10;
  localparam int unsigned MODE_TGT_HIT   = 11;
  localparam int unsigned MODE_OVF_HIT   = 12;
  localparam int unsigned MODE_WR_W      = 10;
  localparam logic [MODE_W-1:0] MODE_RESET = 13'h0400;

  // one request item
  typedef struct packed {
    req_type_e               kind;
    logic [OFF_W-1:0]        offset;
    logic [DATA_W-1:0]       wdata;
  } req_t;

  // one result item
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_pulse;
    logic              access_error;
  } res_t;

endpackage

// ===== src/rct_timer.sv =====
// ----------------------------------------------------------------------------
// rct_timer
// Timer state (counter, prescaler, mode, target) and the combinational
// update for one request item: tick, register read or register write.
// ----------------------------------------------------------------------------
module rct_timer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  rct_pkg::req_t req_i,
  output rct_pkg::res_t res_o
);
  import rct_pkg::*;

  logic [DATA_W-1:0]  count_q, count_d;
  logic [PRESC_W-1:0] presc_q, presc_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [DATA_W-1:0]  target_q, target_d;

  logic [PRESC_W-1:0] presc_next;
  logic               use_presc;
  logic               presc_hit;
  logic               advance;
  logic [DATA_W-1:0]  count_inc;
  logic               tgt_match;
  logic               ovf_match;
  logic               irq_event;
  logic               bad_offset;

  // prescaler step and counter advance
  assign use_presc  = !LINE_PATH || mode_q[MODE_SRC_ODD];
  assign presc_next = presc_q + PRESC_W'(1);
  assign presc_hit  = (presc_next >= PRESC_DIVIDE);
  assign advance    = !use_presc || presc_hit;
  assign count_inc  = count_q + DATA_W'(1);

  // target match wins over wrap to zero
  assign tgt_match  = mode_q[MODE_TGT_IRQ] && (count_inc == target_q);
  assign ovf_match  = !tgt_match && mode_q[MODE_OVF_IRQ] && (count_inc == '0);
  assign irq_event  = advance && (tgt_match || ovf_match);

  assign bad_offset = (req_i.offset != OFF_COUNT) && (req_i.offset != OFF_MODE) &&
                      (req_i.offset != OFF_TARGET);

  // next state and result
  always_comb begin
    count_d  = count_q;
    presc_d  = presc_q;
    mode_d   = mode_q;
    target_d = target_q;
    res_o    = '0;
    case (req_i.kind)
      REQ_TICK: begin
        if (use_presc) begin
          presc_d = presc_hit ? '0 : presc_next;
        end
        if (advance) begin
          count_d = count_inc;
          if (tgt_match) begin
            mode_d[MODE_TGT_HIT] = 1'b1;
            if (mode_q[MODE_TGT_RESET]) begin
              count_d = '0;
            end
          end else if (ovf_match) begin
            mode_d[MODE_OVF_HIT] = 1'b1;
          end
          if (irq_event) begin
            if (mode_q[MODE_TOGGLE]) begin
              // toggle: irq fires when the line goes low
              mode_d[MODE_NIRQ] = ~mode_q[MODE_NIRQ];
              res_o.irq_pulse   = mode_q[MODE_NIRQ];
            end else begin
              mode_d[MODE_NIRQ] = 1'b0;
              res_o.irq_pulse   = 1'b1;
            end
          end
        end
      end
      REQ_READ: begin
        case (req_i.offset)
          OFF_COUNT:  res_o.read_data = count_q;
          OFF_MODE:   res_o.read_data = DATA_W'(mode_q);
          OFF_TARGET: res_o.read_data = target_q;
          default:    res_o.access_error = 1'b1;
        endcase
      end
      REQ_WRITE: begin
        case (req_i.offset)
          OFF_COUNT: count_d = req_i.wdata;
          OFF_MODE: begin
            // keep reached flags, raise irq line, restart counting
            mode_d  = {mode_q[MODE_OVF_HIT:MODE_TGT_HIT], 1'b1,
                       req_i.wdata[MODE_WR_W-1:0]};
            count_d = '0;
            presc_d = '0;
          end
          OFF_TARGET: target_d = req_i.wdata;
          default:    res_o.access_error = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      presc_q  <= '0;
      mode_q   <= MODE_RESET;
      target_q <= '0;
    end else if (fire_i) begin
      count_q  <= count_d;
      presc_q  <= presc_d;
      mode_q   <= mode_d;
      target_q <= target_d;
    end
  end

  // mode write restarts counter and prescaler with the irq line high
  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.kind == REQ_WRITE && req_i.offset == OFF_MODE |=>
      mode_q[MODE_NIRQ] && count_q == '0 && presc_q == '0)
    else $error("mode write did not restart the timer");

  // prescaler stays below its divider
  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    presc_q < PRESC_DIVIDE)
    else $error("prescaler reached its divider");

  // interrupts only come from ticks
  a_irq_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.irq_pulse |-> req_i.kind == REQ_TICK)
    else $error("irq on a non-tick item");

  // read data is zero unless a valid read
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_i.kind != REQ_READ || bad_offset) |-> res_o.read_data == '0)
    else $error("read data driven outside a valid read");

endmodule

// ===== src/root_counter_timer_core.sv =====
// ----------------------------------------------------------------------------
// root_counter_timer_core
// Sixteen-bit counter timer with counter, mode and target registers,
// driven by a stream of tick, read and write items.
// ----------------------------------------------------------------------------
// path: input register, combinational state update, result register
// throughput: one item per cycle while results are taken; while a result
// waits for its consumer one more item is taken into the input register,
// then the input stalls until the result is taken
// reset: counter, prescaler and target clear, mode reads 0x400 (irq high)
module root_counter_timer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [3:0] reg_offset, [19:4] write_data, rest zero
  input  logic [rct_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] req_type
  input  logic [rct_pkg::REQ_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] read_data, [16] irq_pulse, [17] access_error, rest zero
  output logic [rct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import rct_pkg::*;

  logic  in_valid_q;
  req_t  in_req_q;
  logic  out_valid_q;
  res_t  out_res_q;
  res_t  res;
  logic  fire;

  // process the held item when the result register can take it
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q.kind   <= req_type_e'(s_axis_tuser_i);
      in_req_q.offset <= s_axis_tdata_i[OFF_W-1:0];
      in_req_q.wdata  <= s_axis_tdata_i[OFF_W+DATA_W-1:OFF_W];
    end
  end

  rct_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W-DATA_W-2)'(0), out_res_q.access_error,
                            out_res_q.irq_pulse, out_res_q.read_data};

endmodule

// ===== test/root_counter_timer_core_tb.sv =====
// ----------------------------------------------------------------------------
// root_counter_timer_core_tb
// Self-checking bench for the root counter timer. Tick, read, write and
// no-op items go in on the request stream; an item-level predictor of
// the counter, prescaler, mode and target registers works out each reply
// when its item is accepted, and every reply on the result stream is
// compared field by field with the oldest prediction. Both streams idle
// and stall at random.
// ----------------------------------------------------------------------------
module root_counter_timer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rct_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ITEM_GOAL     = 1400;
  localparam int unsigned IDLE_PCT      = 30;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_CYCLES  = 120;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // idling controls shared by the test tasks and the two stream drivers
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int unsigned recv_hold    = 0;

  int unsigned items_sent  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // predicted timer state
  logic [DATA_W-1:0]  timer_count  = '0;
  logic [PRESC_W-1:0] timer_presc  = '0;
  logic [MODE_W-1:0]  timer_mode   = MODE_RESET;
  logic [DATA_W-1:0]  timer_target = '0;

  // replies predicted but not yet seen
  res_t timer_replies_q[$];

  root_counter_timer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // irq line update for a match event, pulse or toggle
  function automatic logic drive_irq_line();
    if (timer_mode[MODE_TOGGLE]) begin
      timer_mode[MODE_NIRQ] = ~timer_mode[MODE_NIRQ];
      return ~timer_mode[MODE_NIRQ];
    end
    timer_mode[MODE_NIRQ] = 1'b0;
    return 1'b1;
  endfunction

  // advance the predicted timer by one item and return its reply
  function automatic res_t predict_timer_reply(req_type_e kind, logic [OFF_W-1:0] off,
                                               logic [DATA_W-1:0] wdata);
    res_t               reply;
    logic [PRESC_W-1:0] presc_next;
    logic               advance;
    reply = '0;
    case (kind)
      REQ_TICK: begin
        advance = 1'b1;
        // undivided path only on timer 1 with the even source
        if (!LINE_PATH || timer_mode[MODE_SRC_ODD]) begin
          presc_next  = timer_presc + 1'b1;
          advance     = (presc_next >= PRESC_DIVIDE);
          timer_presc = advance ? '0 : presc_next;
        end
        if (advance) begin
          timer_count = timer_count + 1'b1;
          // target match wins over wrap to zero
          if (timer_mode[MODE_TGT_IRQ] && timer_count == timer_target) begin
            timer_mode[MODE_TGT_HIT] = 1'b1;
            reply.irq_pulse = drive_irq_line();
            if (timer_mode[MODE_TGT_RESET]) timer_count = '0;
          end else if (timer_mode[MODE_OVF_IRQ] && timer_count == '0) begin
            timer_mode[MODE_OVF_HIT] = 1'b1;
            reply.irq_pulse = drive_irq_line();
          end
        end
      end
      REQ_READ: begin
        case (off)
          OFF_COUNT:  reply.read_data = timer_count;
          OFF_MODE:   reply.read_data = DATA_W'(timer_mode);
          OFF_TARGET: reply.read_data = timer_target;
          default:    reply.access_error = 1'b1;
        endcase
      end
      REQ_WRITE: begin
        case (off)
          OFF_COUNT: timer_count = wdata;
          OFF_MODE: begin
            // reached flags kept, irq line raised, counting restarts
            timer_mode  = {timer_mode[MODE_OVF_HIT:MODE_TGT_HIT], 1'b1,
                           wdata[MODE_WR_W-1:0]};
            timer_count = '0;
            timer_presc = '0;
          end
          OFF_TARGET: timer_target = wdata;
          default:    reply.access_error = 1'b1;
        endcase
      end
      default: ;
    endcase
    return reply;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return DATA_W'($urandom_range(0, 65535));
  endfunction

  // mostly the three registers, sometimes any offset
  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 3))
      0:       return OFF_COUNT;
      1:       return OFF_MODE;
      2:       return OFF_TARGET;
      default: return OFF_W'($urandom_range(0, 15));
    endcase
  endfunction

  // offer one item, wait for it to be taken, then predict its reply
  task automatic send_request(req_type_e kind, logic [OFF_W-1:0] off,
                              logic [DATA_W-1:0] wdata);
    while (send_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= IN_TDATA_W'({wdata, off});
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    timer_replies_q.push_back(predict_timer_reply(kind, off, wdata));
    items_sent++;
  endtask

  // sender goes quiet until every predicted reply has come back
  task automatic wait_for_replies();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (timer_replies_q.size() != 0);
  endtask

  // mode, target and counter set up, then a run of ticks with a few accesses
  task automatic run_timer_burst();
    logic [DATA_W-1:0] tgt;
    logic [DATA_W-1:0] start;
    int unsigned       n_ticks;
    n_ticks = $urandom_range(8, 80);
    send_request(REQ_WRITE, OFF_MODE, rand_word());
    case ($urandom_range(0, 2))
      0: begin
        tgt   = DATA_W'($urandom_range(0, 7));
        start = '0;
      end
      1: begin
        tgt   = rand_word();
        start = tgt - DATA_W'($urandom_range(0, 6));
      end
      default: begin
        tgt   = rand_word();
        start = '1 - DATA_W'($urandom_range(0, 6));
      end
    endcase
    send_request(REQ_WRITE, OFF_TARGET, tgt);
    send_request(REQ_WRITE, OFF_COUNT, start);
    repeat (n_ticks) begin
      case ($urandom_range(0, 15))
        0:       send_request(REQ_READ, pick_offset(), rand_word());
        1:       send_request(REQ_WRITE, OFF_COUNT, tgt - DATA_W'($urandom_range(0, 3)));
        default: send_request(REQ_TICK, OFF_W'($urandom_range(0, 15)), rand_word());
      endcase
    end
    send_request(REQ_READ, OFF_MODE, rand_word());
  endtask

  // bursts mixed with runs of arbitrary items
  task automatic run_random_traffic(int unsigned goal);
    while (items_sent < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 10))
          send_request(req_type_e'($urandom_range(0, 3)), pick_offset(), rand_word());
      end else begin
        run_timer_burst();
      end
    end
  endtask

  task automatic test_reset_state();
    send_request(REQ_READ, OFF_COUNT, '0);
    send_request(REQ_READ, OFF_MODE, '1);
    send_request(REQ_READ, OFF_TARGET, '0);
  endtask

  task automatic test_register_access();
    send_request(REQ_WRITE, OFF_TARGET, '1);
    send_request(REQ_READ, OFF_TARGET, '0);
    send_request(REQ_WRITE, OFF_COUNT, '1);
    send_request(REQ_READ, OFF_COUNT, '0);
    // upper written mode bits are dropped
    send_request(REQ_WRITE, OFF_MODE, '1);
    send_request(REQ_READ, OFF_MODE, '0);
    send_request(REQ_WRITE, OFF_MODE, '0);
    send_request(REQ_READ, OFF_MODE, '0);
    // unknown offsets and a no-op
    send_request(REQ_READ, 4'h1, '0);
    send_request(REQ_READ, '1, '1);
    send_request(REQ_WRITE, 4'hc, '1);
    send_request(REQ_NOP, OFF_MODE, '1);
  endtask

  task automatic test_target_match();
    logic [DATA_W-1:0] mode_wr;
    mode_wr                 = '0;
    mode_wr[MODE_TGT_IRQ]   = 1'b1;
    mode_wr[MODE_TGT_RESET] = 1'b1;
    mode_wr[MODE_TOGGLE]    = 1'b1;
    send_request(REQ_WRITE, OFF_MODE, mode_wr);
    send_request(REQ_WRITE, OFF_TARGET, 16'd3);
    send_request(REQ_WRITE, OFF_COUNT, 16'd2);
    repeat (PRESC_DIVIDE) send_request(REQ_TICK, '0, '0);
    send_request(REQ_READ, OFF_COUNT, '0);
    send_request(REQ_READ, OFF_MODE, '0);
  endtask

  task automatic test_wrap_to_zero();
    logic [DATA_W-1:0] mode_wr;
    mode_wr               = '0;
    mode_wr[MODE_OVF_IRQ] = 1'b1;
    send_request(REQ_WRITE, OFF_MODE, mode_wr);
    send_request(REQ_WRITE, OFF_COUNT, '1);
    repeat (PRESC_DIVIDE) send_request(REQ_TICK, '1, '1);
    send_request(REQ_READ, OFF_MODE, '0);
  endtask

  task automatic test_back_to_back();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    run_random_traffic(ITEM_GOAL * 2 / 3);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // result side held off while items keep coming, so the input stalls
  task automatic test_output_stall();
    send_idle_on = 1'b0;
    recv_hold    = STALL_CYCLES;
    repeat (24) send_request(req_type_e'($urandom_range(0, 3)), pick_offset(), rand_word());
    send_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    wait_for_replies();
    run_timer_burst();
  endtask

  // result side ready, with random idling and requested hold-offs
  initial begin : drive_result_ready
    forever begin
      @(posedge clk_i);
      if (recv_hold != 0) begin
        recv_hold--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= !(recv_idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // compare each reply with the oldest prediction
  always @(posedge clk_i) begin : check_replies
    res_t got_r;
    res_t exp_r;
    if (rst_ni && m_valid && m_ready) begin
      got_r.read_data    = m_tdata[DATA_W-1:0];
      got_r.irq_pulse    = m_tdata[DATA_W];
      got_r.access_error = m_tdata[DATA_W+1];
      if (timer_replies_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("cycle %0d: reply with none expected: rd=%h irq=%b err=%b",
                   cycle_count, got_r.read_data, got_r.irq_pulse, got_r.access_error);
      end else begin
        exp_r = timer_replies_q.pop_front();
        if (got_r.read_data !== exp_r.read_data || got_r.irq_pulse !== exp_r.irq_pulse ||
            got_r.access_error !== exp_r.access_error ||
            m_tdata[OUT_TDATA_W-1:DATA_W+2] !== '0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("cycle %0d: expected rd=%h irq=%b err=%b, got rd=%h irq=%b err=%b pad=%h",
                     cycle_count, exp_r.read_data, exp_r.irq_pulse, exp_r.access_error,
                     got_r.read_data, got_r.irq_pulse, got_r.access_error,
                     m_tdata[OUT_TDATA_W-1:DATA_W+2]);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run limit of %0d cycles reached", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // test sequence
  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_register_access();
    test_target_match();
    test_wrap_to_zero();
    run_random_traffic(ITEM_GOAL / 3);
    test_back_to_back();
    test_output_stall();
    test_sender_pause();
    run_random_traffic(ITEM_GOAL);
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (timer_replies_q.size() != 0) begin
      fail_count++;
      $display("%0d expected replies never arrived", timer_replies_q.size());
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
